[sv/lst_pkg.sv]
package lst_pkg;

  // Fixed field widths of the two channels.
  localparam int LINE_W      = 14;
  localparam int THREAD_ID_W = 16;
  localparam int PEER_W      = 3;
  localparam int DEG_W       = 4;

  // Access codes carried in the opcode field.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Number of distinct line indexes that the input field can name.
  localparam longint unsigned LINE_SPACE = 64'(1) << LINE_W;

  // Shift amounts of the reciprocal multiplications that reduce the line
  // index and the thread number modulo their constant ranges.
  localparam int LINE_RECIP_SH   = 2 * LINE_W;
  localparam int THREAD_RECIP_SH = 2 * THREAD_ID_W;

  typedef struct packed {
    logic                   opcode;
    logic [LINE_W-1:0]      line_index;
    logic [THREAD_ID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    logic [PEER_W-1:0] peer_thread;
    logic [DEG_W-1:0]  accessor_cnt;
    logic [DEG_W-1:0]  writer_cnt;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic mul;
    logic sub;
    logic fix;
    logic rd;
    logic calc;
    logic cnt_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic count_last;
    logic out_busy;
  } status_t;

endpackage

[sv/lst_ctrl.sv]
module lst_ctrl
  import lst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  status_t status,
  output logic    req_stall,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_SUB   = 9'b000001000,
    S_FIX   = 9'b000010000,
    S_READ  = 9'b000100000,
    S_CALC  = 9'b001000000,
    S_COUNT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub    = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_COUNT;
      end
      S_COUNT: begin
        cmd.cnt_step = 1'b1;
        if (status.count_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  // The entry update must use data read in the cycle just before.
  a_calc_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.calc |-> $past(cmd.rd))
    else $error("entry update without a preceding read");

  // No transaction is taken before the clearing pass has finished.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.load_in && req_stall)
    else $error("request accepted during clearing pass");

  // The controller is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state is not one-hot");

endmodule

[sv/lst_dp.sv]
module lst_dp
  import lst_pkg::*;
#(
  parameter int THREADS        = 8,
  parameter int LINES_PER_PAGE = 64,
  parameter int PAGES          = 256,
  parameter int VERSION_WIDTH  = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  req_t    req,
  input  logic    rsp_stall,
  output logic    rsp_valid,
  output rsp_t    rsp,
  output status_t status
);

  localparam longint unsigned NLINES = 64'(PAGES) * 64'(LINES_PER_PAGE);
  localparam longint unsigned DEPTH  = (NLINES < LINE_SPACE) ? NLINES : LINE_SPACE;
  localparam int LW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW     = $clog2(THREADS);
  localparam int VW     = VERSION_WIDTH;
  localparam int SW     = LW + TW;
  localparam longint unsigned SDEPTH = DEPTH << TW;
  localparam int ROW_W  = 2 * THREADS + TW + VW;
  localparam int NCH    = (THREADS + 7) / 8;
  localparam int CW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int CNTW   = $clog2(THREADS + 1);
  localparam int PXW    = (TW > PEER_W) ? TW : PEER_W;
  localparam int DXW    = (CNTW > DEG_W) ? CNTW : DEG_W;
  localparam int TM_W   = THREAD_RECIP_SH + 1;
  localparam longint unsigned THREAD_RECIP = (64'(1) << THREAD_RECIP_SH) / 64'(THREADS);
  localparam logic [TM_W-1:0] TM_C = TM_W'(THREAD_RECIP);
  localparam logic [THREAD_ID_W-1:0] TN_C = THREAD_ID_W'(THREADS);

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Captured request.
  logic                   op;
  logic [LINE_W-1:0]      xl;
  logic [THREAD_ID_W-1:0] xt;

  // Thread reduction.
  logic [THREAD_ID_W+TM_W-1:0] pt;
  logic [THREAD_ID_W-1:0]      rt0;
  logic [THREAD_ID_W-1:0]      qt;

  // Reduced address.
  logic [LW-1:0] line;
  logic [TW-1:0] tid;

  // Memories and their registered read data.
  logic [ROW_W-1:0] line_mem [DEPTH];
  logic [VW-1:0]    seen_mem [SDEPTH];
  logic [ROW_W-1:0] row_rd;
  logic [VW-1:0]    seen_rd;

  // Clearing pass.
  logic [SW-1:0] clr_cnt;

  // Entry update.
  logic [VW-1:0]      cur_ver;
  logic [TW-1:0]      cur_owner;
  logic [THREADS-1:0] cur_amask, cur_wmask, tbit;
  logic [THREADS-1:0] new_amask, new_wmask;
  logic [TW-1:0]      new_owner, peer_calc;
  logic [VW-1:0]      new_ver;
  logic [ROW_W-1:0]   row_wr;

  // Counting.
  logic [TW-1:0]        peer;
  logic [NCH*8-1:0]     amask_pad, wmask_pad;
  logic [CW-1:0]        ch;
  logic [CNTW-1:0]      acc_a, acc_w;
  logic [PXW-1:0]       peer_ext;
  logic [DXW-1:0]       acc_a_ext, acc_w_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op <= req.opcode;
      xl <= req.line_index;
      xt <= req.thread_id;
    end
  end

  // Line reduction: the index wraps modulo the table size.
  generate
    if (NLINES < LINE_SPACE) begin : g_line_mod
      localparam int LM_W = LINE_RECIP_SH + 1;
      localparam longint unsigned LINE_RECIP = (64'(1) << LINE_RECIP_SH) / NLINES;
      localparam logic [LM_W-1:0]   LM_C = LM_W'(LINE_RECIP);
      localparam logic [LINE_W-1:0] LN_C = LINE_W'(NLINES);
      logic [LINE_W+LM_W-1:0] pl;
      logic [LINE_W-1:0]      ql;
      logic [LINE_W-1:0]      rl0;
      logic [2*LINE_W-1:0]    qn;
      assign ql = pl[LINE_RECIP_SH +: LINE_W];
      assign qn = ql * LN_C;
      always_ff @(posedge clk) begin
        if (cmd.mul) begin
          pl <= xl * LM_C;
        end
        if (cmd.sub) begin
          rl0 <= xl - qn[LINE_W-1:0];
        end
        if (cmd.fix) begin
          line <= (rl0 >= LN_C) ? LW'(rl0 - LN_C) : LW'(rl0);
        end
      end
    end else begin : g_line_pass
      always_ff @(posedge clk) begin
        if (cmd.fix) begin
          line <= LW'(xl);
        end
      end
    end
  endgenerate

  assign qt = pt[THREAD_RECIP_SH +: THREAD_ID_W];

  always_ff @(posedge clk) begin
    logic [2*THREAD_ID_W-1:0] qtn;
    qtn = qt * TN_C;
    if (cmd.mul) begin
      pt <= xt * TM_C;
    end
    if (cmd.sub) begin
      rt0 <= xt - qtn[THREAD_ID_W-1:0];
    end
    if (cmd.fix) begin
      tid <= (rt0 >= TN_C) ? TW'(rt0 - TN_C) : TW'(rt0);
    end
  end

  // Clearing pass over both stores after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step && !status.clr_last) begin
      clr_cnt <= clr_cnt + SW'(1);
    end
  end

  assign status.clr_last = (clr_cnt == SW'(SDEPTH - 1));

  // Row layout: written mask, accessed mask, owner, version.
  assign cur_ver   = row_rd[VW-1:0];
  assign cur_owner = row_rd[VW +: TW];
  assign cur_amask = row_rd[VW+TW +: THREADS];
  assign cur_wmask = row_rd[VW+TW+THREADS +: THREADS];
  assign tbit      = THREADS'(1) << tid;

  always_comb begin
    new_amask = cur_amask | tbit;
    if (op == OP_WRITE) begin
      peer_calc = cur_owner;
      new_owner = tid;
      new_ver   = cur_ver + VW'(1);
      new_wmask = cur_wmask | tbit;
    end else begin
      peer_calc = (cur_ver != seen_rd) ? cur_owner : tid;
      new_owner = cur_owner;
      new_ver   = cur_ver;
      new_wmask = cur_wmask;
    end
    row_wr = {new_wmask, new_amask, new_owner, new_ver};
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      line_mem[clr_cnt[SW-1:TW]] <= '0;
    end else if (cmd.calc) begin
      line_mem[line] <= row_wr;
    end
    if (cmd.rd) begin
      row_rd <= line_mem[line];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      seen_mem[clr_cnt] <= '0;
    end else if (cmd.calc) begin
      seen_mem[{line, tid}] <= cur_ver;
    end
    if (cmd.rd) begin
      seen_rd <= seen_mem[{line, tid}];
    end
  end

  // Degrees are counted one byte of the masks per cycle.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      peer      <= peer_calc;
      amask_pad <= (NCH*8)'(new_amask);
      wmask_pad <= (NCH*8)'(new_wmask);
      ch        <= '0;
      acc_a     <= '0;
      acc_w     <= '0;
    end else if (cmd.cnt_step) begin
      ch    <= ch + CW'(1);
      acc_a <= acc_a + CNTW'(pop8(amask_pad[ch*8 +: 8]));
      acc_w <= acc_w + CNTW'(pop8(wmask_pad[ch*8 +: 8]));
    end
  end

  assign status.count_last = (ch == CW'(NCH - 1));

  assign peer_ext  = PXW'(peer);
  assign acc_a_ext = DXW'(acc_a);
  assign acc_w_ext = DXW'(acc_w);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.peer_thread  <= peer_ext[PEER_W-1:0];
      rsp.accessor_cnt <= acc_a_ext[DEG_W-1:0];
      rsp.writer_cnt   <= acc_w_ext[DEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign status.out_busy = rsp_valid && rsp_stall;

  // The reduced address must lie inside both stores when they are read.
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (longint'(line) < DEPTH) && (int'(tid) < THREADS))
    else $error("reduced line or thread out of range");

  // A held result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(rsp_valid && rsp_stall))
    else $error("result register loaded while still held");

  // Counting always starts from the update of an access.
  a_count_after_calc: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_step && !$past(cmd.cnt_step)) |-> $past(cmd.calc))
    else $error("degree count started without an entry update");

endmodule

[sv/line_sharing_tracker.sv]
// Line sharing tracker: profiles how threads communicate through cache lines.
// The req channel carries one access per transaction (read or write, line
// index, thread id); the rsp channel returns one result per access: the peer
// thread, and how many threads have accessed and written the line so far.
// Both channels use valid/stall: a transaction completes at a clock edge with
// valid high and stall low.
// Each access walks a controller through a fixed sequence: capture, two
// reciprocal-multiply steps and a correction that wrap the line index and
// thread id into range, the registered memory reads, the entry update and
// write-back, the degree count, which takes one byte of the thread masks per
// cycle, and the load of the output register. A single read-modify-write
// path serves both memories, so accesses are taken one at a time.
// After reset, rst synchronous and active high, req_stall stays high while a
// clearing pass zeroes both memories, one seen-version entry per cycle.
// If the receiver stalls, the result waits in the output register while the
// next access is taken and processed; that one waits until the register frees.
module line_sharing_tracker
  import lst_pkg::*;
#(
  parameter int THREADS        = 8,
  parameter int LINES_PER_PAGE = 64,
  parameter int PAGES          = 256,
  parameter int VERSION_WIDTH  = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t    cmd;
  status_t status;

  // The controller sequences each transaction and the clearing pass.
  lst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  // The datapath holds the line and seen-version memories, the index
  // reduction, the entry update and the output register.
  lst_dp #(
    .THREADS        (THREADS),
    .LINES_PER_PAGE (LINES_PER_PAGE),
    .PAGES          (PAGES),
    .VERSION_WIDTH  (VERSION_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .status    (status)
  );

endmodule
